// ===== design/lhc_pkg.sv =====
// Shared types, widths and status codes for the LRU handle cache.
package lhc_pkg;

	// Field widths
	localparam int KEY_W    = 16;
	localparam int HANDLE_W = 12;
	localparam int STAMP_W  = 32;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 3;

	// Default table size and depth of the request queue
	localparam int ENTRIES_DEF = 8;
	localparam int Q_DEPTH     = 2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FILL       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EVICT      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CLOSE_FAIL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OPEN_FAIL  = 3'd4;

	// One request as it travels from front to back, with its access stamp
	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] open_handle;
		logic                open_ok;
		logic                close_ok;
		logic [STAMP_W-1:0]  stamp;
	} req_t;

endpackage

// ===== design/lhc_front.sv =====
// Front end: takes requests, stamps each with the advancing tick, pushes to the queue.
module lhc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lhc_pkg::KEY_W-1:0]     key,
	input  logic [lhc_pkg::HANDLE_W-1:0]  open_handle,
	input  logic                          open_ok,
	input  logic                          close_ok,
	input  logic                          q_full,
	output logic                          q_push,
	output lhc_pkg::req_t                 q_req
);
	import lhc_pkg::*;

	logic [STAMP_W-1:0] tick_q;
	logic [STAMP_W-1:0] tick_next;

	// Every accepted request advances the tick; it wraps at 32 bits
	assign tick_next = tick_q + STAMP_W'(1);
	assign in_ready  = !q_full;
	assign q_push    = in_valid && in_ready;

	always_comb begin
		q_req.key         = key;
		q_req.open_handle = open_handle;
		q_req.open_ok     = open_ok;
		q_req.close_ok    = close_ok;
		q_req.stamp       = tick_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (q_push) begin
			tick_q <= tick_next;
		end
	end

endmodule

// ===== design/lhc_queue.sv =====
// Short request queue between the front end and the table engine.
module lhc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lhc_pkg::req_t push_req,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output lhc_pkg::req_t head_req
);
	import lhc_pkg::*;

	localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCW = $clog2(Q_DEPTH + 1);
	localparam logic [QAW-1:0] LAST_PTR = QAW'(Q_DEPTH - 1);
	localparam logic [QCW-1:0] FULL_CNT = QCW'(Q_DEPTH);

	req_t           slots_q [Q_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_req   = slots_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_req;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	// Fill count never passes the depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count out of range");

endmodule

// ===== design/lhc_back.sv =====
// Table engine: key lookup, empty-slot fill, LRU victim scan and result register.
module lhc_back #(
	parameter int ENTRIES = lhc_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  lhc_pkg::req_t                 q_req,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lhc_pkg::STATUS_W-1:0]  status,
	output logic [lhc_pkg::HANDLE_W-1:0]  handle,
	output logic [lhc_pkg::SLOT_W-1:0]    slot,
	output logic [lhc_pkg::HANDLE_W-1:0]  victim_handle
);
	import lhc_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	// Sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]          state_q;
	req_t                req_q;
	logic [KEY_W-1:0]    key_q    [ENTRIES];
	logic [HANDLE_W-1:0] handle_q [ENTRIES];
	logic [STAMP_W-1:0]  stamp_q  [ENTRIES];
	logic [IW-1:0]       cnt_q;
	logic [IW-1:0]       best_idx_q;
	logic [STAMP_W-1:0]  best_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [HANDLE_W-1:0] handle_out_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [HANDLE_W-1:0] victim_q;

	logic [ENTRIES-1:0]  hit_vec;
	logic [ENTRIES-1:0]  empty_vec;
	logic [IW-1:0]       hit_idx;
	logic [IW-1:0]       empty_idx;
	logic                any_hit;
	logic                any_empty;
	logic [IW-1:0]       rd_idx;
	logic [HANDLE_W-1:0] rd_handle;
	logic [STAMP_W-1:0]  scan_stamp;
	logic                can_emit;

	logic                emit;
	logic [STATUS_W-1:0] emit_status;
	logic [HANDLE_W-1:0] emit_handle;
	logic [IW-1:0]       emit_idx;
	logic [HANDLE_W-1:0] emit_victim;
	logic                wr_entry;
	logic                wr_stamp;
	logic [IW-1:0]       wr_idx;
	logic                start_scan;
	logic [1:0]          state_next;

	// Parallel key match and empty detect, lowest index wins
	always_comb begin
		hit_idx   = '0;
		empty_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			hit_vec[i]   = (key_q[i] != '0) && (key_q[i] == req_q.key);
			empty_vec[i] = (key_q[i] == '0);
			if (hit_vec[i]) begin
				hit_idx = IW'(i);
			end
			if (empty_vec[i]) begin
				empty_idx = IW'(i);
			end
		end
	end

	assign any_hit   = |hit_vec;
	assign any_empty = |empty_vec;

	// Single handle read port; stamps are read at the scan index and at slot 0
	assign rd_idx     = (state_q == S_FIN) ? best_idx_q : hit_idx;
	assign rd_handle  = handle_q[rd_idx];
	assign scan_stamp = stamp_q[cnt_q];
	assign can_emit   = !out_valid_q || out_ready;

	// Per-state action decode
	always_comb begin
		emit        = 1'b0;
		emit_status = ST_HIT;
		emit_handle = '0;
		emit_idx    = '0;
		emit_victim = '0;
		wr_entry    = 1'b0;
		wr_stamp    = 1'b0;
		wr_idx      = '0;
		start_scan  = 1'b0;
		q_pop       = 1'b0;
		state_next  = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop      = 1'b1;
					state_next = S_LOOK;
				end
			end
			S_LOOK: begin
				if (any_hit) begin
					if (can_emit) begin
						emit        = 1'b1;
						emit_status = ST_HIT;
						emit_handle = rd_handle;
						emit_idx    = hit_idx;
						wr_stamp    = 1'b1;
						wr_idx      = hit_idx;
						state_next  = S_IDLE;
					end
				end else if (any_empty) begin
					if (can_emit) begin
						emit       = 1'b1;
						emit_idx   = empty_idx;
						state_next = S_IDLE;
						if (req_q.open_ok) begin
							emit_status = ST_FILL;
							emit_handle = req_q.open_handle;
							wr_entry    = 1'b1;
							wr_idx      = empty_idx;
						end else begin
							emit_status = ST_OPEN_FAIL;
						end
					end
				end else begin
					start_scan = 1'b1;
					state_next = S_SCAN;
				end
			end
			S_SCAN: begin
				if (cnt_q == LAST_IDX) begin
					state_next = S_FIN;
				end
			end
			S_FIN: begin
				if (can_emit) begin
					emit       = 1'b1;
					emit_idx   = best_idx_q;
					state_next = S_IDLE;
					if (!req_q.close_ok) begin
						emit_status = ST_CLOSE_FAIL;
						emit_victim = rd_handle;
					end else if (!req_q.open_ok) begin
						emit_status = ST_OPEN_FAIL;
					end else begin
						emit_status = ST_EVICT;
						emit_handle = req_q.open_handle;
						emit_victim = rd_handle;
						wr_entry    = 1'b1;
						wr_idx      = best_idx_q;
					end
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// Control state, keys (zero marks empty) and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				key_q[i] <= '0;
			end
		end else begin
			state_q <= state_next;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_entry) begin
				key_q[wr_idx] <= req_q.key;
			end
		end
	end

	// Payload: held request, handles, stamps, scan registers, result fields
	always_ff @(posedge clk) begin
		if (q_pop) begin
			req_q <= q_req;
		end
		if (wr_entry) begin
			handle_q[wr_idx] <= req_q.open_handle;
		end
		if (wr_entry || wr_stamp) begin
			stamp_q[wr_idx] <= req_q.stamp;
		end
		if (start_scan) begin
			best_q     <= stamp_q[0];
			best_idx_q <= '0;
			cnt_q      <= IW'(1);
		end else if (state_q == S_SCAN) begin
			if (scan_stamp < best_q) begin
				best_q     <= scan_stamp;
				best_idx_q <= cnt_q;
			end
			if (cnt_q != LAST_IDX) begin
				cnt_q <= cnt_q + IW'(1);
			end
		end
		if (emit) begin
			status_q     <= emit_status;
			handle_out_q <= emit_handle;
			slot_q       <= SLOT_W'(emit_idx);
			victim_q     <= emit_victim;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign handle        = handle_out_q;
	assign slot          = slot_q;
	assign victim_handle = victim_q;

	// A nonzero key is only inserted on a miss, so it sits in at most one slot
	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("key present in more than one slot");

	// The victim scan only runs on a full table
	a_scan_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_FIN) |-> (empty_vec == '0))
		else $error("victim scan with an empty slot present");

	// Scan index stays inside the table
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (cnt_q <= LAST_IDX))
		else $error("scan index past the last slot");

	// A result is only loaded when the output register is free or draining
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

endmodule

// ===== design/lru_handle_cache.sv =====
// Top level of the LRU handle cache: front end, request queue and table engine.
//
// Use: a request carries a nonzero key plus the outcome of an external open
// (open_ok, open_handle) and of an external close (close_ok), used only on a
// miss. Each request gives exactly one result: status, handle, slot and
// victim_handle, on a valid/ready channel of its own.
// Path: an accepted request is queued, popped into the held request register,
// looked up, and its result loaded into the output register. A miss on a full
// table adds a victim scan over the stamps, one stamp per cycle.
// Overlap: the table engine handles one request at a time and takes the next
// only once it is through with the last. The front end stamps requests with
// the tick and keeps accepting until the two-deep queue is full.
// Reset: all slots empty, tick zero, queue empty, no result pending.
// Stall: a result waits in the output register while out_ready is low; the
// engine holds the next request until that register frees, and the input
// side backs up through the queue.
module lru_handle_cache #(
	parameter int ENTRIES = lhc_pkg::ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lhc_pkg::KEY_W-1:0]     key,
	input  logic [lhc_pkg::HANDLE_W-1:0]  open_handle,
	input  logic                          open_ok,
	input  logic                          close_ok,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lhc_pkg::STATUS_W-1:0]  status,
	output logic [lhc_pkg::HANDLE_W-1:0]  handle,
	output logic [lhc_pkg::SLOT_W-1:0]    slot,
	output logic [lhc_pkg::HANDLE_W-1:0]  victim_handle
);
	import lhc_pkg::*;

	logic q_full;
	logic q_push;
	req_t push_req;
	logic q_pop;
	logic q_valid;
	req_t head_req;

	lhc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.key         (key),
		.open_handle (open_handle),
		.open_ok     (open_ok),
		.close_ok    (close_ok),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_req       (push_req)
	);

	lhc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_req   (push_req),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_req   (head_req)
	);

	lhc_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_req         (head_req),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.handle        (handle),
		.slot          (slot),
		.victim_handle (victim_handle)
	);

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the LRU handle cache: directed and random lookups, LRU predictor.
`timescale 1ns / 100ps

module tb;
	import lhc_pkg::*;

	localparam int NUM_SLOTS   = ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 750;
	localparam int HOLD_CYCLES = 200;
	localparam int POOL_SIZE   = 12;

	// One expected lookup outcome
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] handle;
		logic [SLOT_W-1:0]   slot;
		logic [HANDLE_W-1:0] victim;
	} lookup_result_t;

	// Shadow table of the cache and the outcomes still owed by the block
	class lru_scoreboard;
		logic [KEY_W-1:0]    keys[NUM_SLOTS];
		logic [HANDLE_W-1:0] handles[NUM_SLOTS];
		logic [STAMP_W-1:0]  stamps[NUM_SLOTS];
		logic [STAMP_W-1:0]  tick;
		lookup_result_t      owed[$];
		int                  errors;

		function new();
			for (int i = 0; i < NUM_SLOTS; i++) begin
				keys[i]    = '0;
				handles[i] = '0;
				stamps[i]  = '0;
			end
			tick   = '0;
			errors = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Work out the outcome of one accepted request and update the shadow table
		function void note(logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] oh, logic ook, logic cok);
			lookup_result_t r;
			int idx;
			bit evict;
			logic [STAMP_W-1:0] best;
			tick   = tick + 1'b1;
			idx    = -1;
			evict  = 0;
			r.status = ST_HIT;
			r.handle = '0;
			r.slot   = '0;
			r.victim = '0;
			// Key zero never matches, an empty slot holds key zero
			for (int i = 0; i < NUM_SLOTS; i++)
				if (idx < 0 && keys[i] != '0 && keys[i] == k)
					idx = i;
			if (idx >= 0) begin
				stamps[idx] = tick;
				r.handle    = handles[idx];
				r.slot      = SLOT_W'(idx);
			end else begin
				for (int i = 0; i < NUM_SLOTS; i++)
					if (idx < 0 && keys[i] == '0)
						idx = i;
				// Table full: oldest stamp, ties to the lower index
				if (idx < 0) begin
					idx   = 0;
					best  = stamps[0];
					evict = 1;
					for (int i = 1; i < NUM_SLOTS; i++)
						if (stamps[i] < best) begin
							best = stamps[i];
							idx  = i;
						end
				end
				r.slot = SLOT_W'(idx);
				if (evict && !cok) begin
					r.status = ST_CLOSE_FAIL;
					r.victim = handles[idx];
				end else if (!ook) begin
					r.status = ST_OPEN_FAIL;
				end else begin
					r.status     = evict ? ST_EVICT : ST_FILL;
					r.handle     = oh;
					r.victim     = evict ? handles[idx] : '0;
					keys[idx]    = k;
					handles[idx] = oh;
					stamps[idx]  = tick;
				end
			end
			owed.push_back(r);
		endfunction

		// Compare one delivered result with the oldest outcome owed
		function void check(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] hd,
				logic [SLOT_W-1:0] sl, logic [HANDLE_W-1:0] vh);
			lookup_result_t e;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result status=%0d handle=%0h slot=%0d victim=%0h",
					$time, st, hd, sl, vh);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (st !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
			if (hd !== e.handle) begin
				$display("%0t: handle expected %0h actual %0h", $time, e.handle, hd);
				errors++;
			end
			if (sl !== e.slot) begin
				$display("%0t: slot expected %0d actual %0d", $time, e.slot, sl);
				errors++;
			end
			if (vh !== e.victim) begin
				$display("%0t: victim_handle expected %0h actual %0h", $time, e.victim, vh);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [KEY_W-1:0]    key = '0;
	logic [HANDLE_W-1:0] open_handle = '0;
	logic                open_ok = 1'b0;
	logic                close_ok = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] handle;
	logic [SLOT_W-1:0]   slot;
	logic [HANDLE_W-1:0] victim_handle;

	lru_scoreboard       cache_sb;
	int                  phase = 0;
	int                  cycles = 0;
	logic [KEY_W-1:0]    key_pool[POOL_SIZE];

	lru_handle_cache #(.ENTRIES(NUM_SLOTS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.key(key),
		.open_handle(open_handle),
		.open_ok(open_ok),
		.close_ok(close_ok),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.handle(handle),
		.slot(slot),
		.victim_handle(victim_handle)
	);

	always #6 clk = ~clk;

	// Run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function int sender_idle();
		return (phase == 0) ? 31 : (phase == 1) ? 81 : 0;
	endfunction

	function int receiver_idle();
		return (phase == 0) ? 81 : (phase == 1) ? 31 : 0;
	endfunction

	// Offer one request, with random gaps ahead of it, and note it once taken
	task automatic offer_request(logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] oh,
			logic ook, logic cok);
		while ($urandom_range(99) < sender_idle()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		key         <= k;
		open_handle <= oh;
		open_ok     <= ook;
		close_ok    <= cok;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		cache_sb.note(k, oh, ook, cok);
	endtask

	// Random request: mostly keys from a small pool so hits and evictions mix
	task automatic offer_random();
		logic [KEY_W-1:0] k;
		int pick;
		pick = $urandom_range(99);
		if (pick < 4)
			key_pool[$urandom_range(POOL_SIZE - 1)] = KEY_W'($urandom_range(65535, 1));
		if (pick < 82)
			k = key_pool[$urandom_range(POOL_SIZE - 1)];
		else
			k = KEY_W'($urandom_range(65535, 1));
		offer_request(k, HANDLE_W'($urandom_range(4095)),
			$urandom_range(99) < 88, $urandom_range(99) < 88);
	endtask

	// Result side: check each taken result, then pick ready for the next edge
	initial begin : result_side
		int hold;
		bit held;
		hold = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				cache_sb.check(status, handle, slot, victim_handle);
			// Long hold-off once, so the queue fills and input stalls
			if (phase == 2 && !held) begin
				held = 1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_idle());
			end
		end
	end

	// Request side and end of run
	initial begin : request_side
		cache_sb = new();
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = KEY_W'($urandom_range(65535, 1));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill from empty, key extremes, a hit and a failed open
		offer_request(16'h0001, 12'hFFF, 1'b1, 1'b1);
		offer_request(16'hFFFF, 12'h000, 1'b1, 1'b1);
		offer_request(16'h0001, 12'h123, 1'b0, 1'b0);
		offer_request(16'h1234, 12'h456, 1'b0, 1'b1);
		// Key zero fills a slot that stays empty
		offer_request(16'h0000, 12'h789, 1'b1, 1'b1);
		for (int i = 2; i < 8; i++)
			offer_request(KEY_W'(i), HANDLE_W'(12'h100 + i), 1'b1, 1'b1);
		offer_request(16'hFFFF, 12'hABC, 1'b1, 1'b0);
		// Full table: failed close, failed open, then clean evictions
		offer_request(16'h4000, 12'h111, 1'b1, 1'b0);
		offer_request(16'h4001, 12'h222, 1'b0, 1'b1);
		offer_request(16'hA5A5, 12'hA5A, 1'b1, 1'b1);
		// Key zero on a full table evicts and leaves the slot empty
		offer_request(16'h0000, 12'h333, 1'b1, 1'b1);
		offer_request(16'h8000, 12'h800, 1'b1, 1'b1);
		offer_request(16'h0001, 12'h000, 1'b1, 1'b1);
		offer_request(16'h5A5A, 12'h5A5, 1'b1, 1'b1);
		offer_request(16'h7FFF, 12'h7FF, 1'b1, 1'b1);

		// Random part in three idling phases
		for (int p = 0; p < 3; p++) begin
			phase = p;
			for (int n = 0; n < RAND_ITEMS / 3; n++)
				offer_random();
		end
		in_valid <= 1'b0;

		while (cache_sb.pending() != 0)
			@(posedge clk);
		repeat (NUM_SLOTS + 12) @(posedge clk);
		if (cache_sb.pending() != 0) begin
			$display("%0t: %0d results never arrived", $time, cache_sb.pending());
			cache_sb.errors++;
		end
		if (cache_sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
